// File: hdl/sckc_pkg.sv
// Shared types and constants of the second-chance key cache.
package sckc_pkg;

   localparam int KEY_W         = 32;
   localparam int LEN_W         = 22;
   localparam int CFG_W         = 15;
   localparam int STAT_W        = 32;
   localparam int DEF_CAPACITY  = 16384;
   localparam int DEF_MAX_LEN   = 2097152;
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16384);
   localparam logic [STAT_W-1:0] STAT_MAX = '1;

   typedef struct packed {
      logic [KEY_W-1:0] chunk_x;
      logic [KEY_W-1:0] chunk_z;
      logic             fill_ok;
      logic [LEN_W-1:0] fill_length;
   } req_type;

endpackage

// File: hdl/second_chance_key_cache_unit.sv
// Top level of the second-chance key cache: front queue, back engine.
//
//   channel   ports        handshake              moves
//   request   req_*        push / full            one key access item
//   response  rsp_*        empty / pop            one result item
//   config    csr_*        csr_we                 max_entries
//
// An item is taken in an accept state, then each held entry walked takes ring, key and
// compare reads; a hit ends the walk. A miss passes the miss state; a filled miss then
// tests for eviction, reads ring, ref, check per candidate, keys per eviction, inserts.
// The back engine works one item at a time and takes no item while a result waits.
// Reset is synchronous; no memory clearing pass.
// The front queue holds two items, so up to two requests are still taken while a result waits.
module second_chance_key_cache_unit #(
   parameter int CAPACITY   = sckc_pkg::DEF_CAPACITY,
   parameter int MAX_LENGTH = sckc_pkg::DEF_MAX_LEN,
   localparam int SW = $clog2(CAPACITY),
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [sckc_pkg::CFG_W-1:0]          csr_wdata,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [sckc_pkg::KEY_W-1:0]   req_chunk_x,
   input  logic signed [sckc_pkg::KEY_W-1:0]   req_chunk_z,
   input  logic                                req_fill_ok,
   input  logic [sckc_pkg::LEN_W-1:0]          req_fill_length,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_hit,
   output logic                                rsp_present,
   output logic [SW-1:0]                       rsp_slot,
   output logic [sckc_pkg::LEN_W-1:0]          rsp_length,
   output logic [CW-1:0]                       rsp_evictions_now,
   output logic signed [sckc_pkg::KEY_W-1:0]   rsp_evicted_x,
   output logic signed [sckc_pkg::KEY_W-1:0]   rsp_evicted_z,
   output logic [sckc_pkg::STAT_W-1:0]         rsp_hits_total,
   output logic [sckc_pkg::STAT_W-1:0]         rsp_misses_total,
   output logic [sckc_pkg::STAT_W-1:0]         rsp_evictions_total,
   output logic [CW-1:0]                       rsp_entries_held
);

   logic              item_valid, item_pop;
   sckc_pkg::req_type item;
   logic [sckc_pkg::KEY_W-1:0] ev_x, ev_z;

   sckc_front #(.MAX_LENGTH(MAX_LENGTH)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_chunk_x     (req_chunk_x),
      .req_chunk_z     (req_chunk_z),
      .req_fill_ok     (req_fill_ok),
      .req_fill_length (req_fill_length),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop)
   );

   sckc_back #(.CAPACITY(CAPACITY)) u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .item_valid          (item_valid),
      .item                (item),
      .item_pop            (item_pop),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_hit             (rsp_hit),
      .rsp_present         (rsp_present),
      .rsp_slot            (rsp_slot),
      .rsp_length          (rsp_length),
      .rsp_evictions_now   (rsp_evictions_now),
      .rsp_evicted_x       (ev_x),
      .rsp_evicted_z       (ev_z),
      .rsp_hits_total      (rsp_hits_total),
      .rsp_misses_total    (rsp_misses_total),
      .rsp_evictions_total (rsp_evictions_total),
      .rsp_entries_held    (rsp_entries_held)
   );

   assign rsp_evicted_x = signed'(ev_x);
   assign rsp_evicted_z = signed'(ev_z);

endmodule

// File: hdl/sckc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sckc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: hdl/sckc_front.sv
// Front end: accepts items, clamps the fill length, holds them in a two-entry queue.
module sckc_front #(
   parameter int MAX_LENGTH = sckc_pkg::DEF_MAX_LEN
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [sckc_pkg::KEY_W-1:0]  req_chunk_x,
   input  logic [sckc_pkg::KEY_W-1:0]  req_chunk_z,
   input  logic                        req_fill_ok,
   input  logic [sckc_pkg::LEN_W-1:0]  req_fill_length,
   output logic                        item_valid,
   output sckc_pkg::req_type           item,
   input  logic                        item_pop
);

   sckc_pkg::req_type q_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok;
   sckc_pkg::req_type in_item;

   assign req_full   = (cnt_ff == 2'd2);
   assign push_ok    = req_push && !req_full;
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rd_ff];

   always_comb begin
      in_item.chunk_x = req_chunk_x;
      in_item.chunk_z = req_chunk_z;
      in_item.fill_ok = req_fill_ok;
      if (32'(req_fill_length) > 32'(MAX_LENGTH)) begin
         in_item.fill_length = sckc_pkg::LEN_W'(MAX_LENGTH);
      end else begin
         in_item.fill_length = req_fill_length;
      end
      wr_in  = push_ok ? ~wr_ff : wr_ff;
      rd_in  = item_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push_ok) - 2'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push_ok) begin
         q_ff[wr_ff] <= in_item;
      end
   end

endmodule

// File: hdl/sckc_back.sv
// Back end: lookup over the age ring, second-chance eviction, insertion, result register.
module sckc_back #(
   parameter int CAPACITY = sckc_pkg::DEF_CAPACITY,
   localparam int SW = $clog2(CAPACITY),
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [sckc_pkg::CFG_W-1:0]    csr_wdata,
   input  logic                          item_valid,
   input  sckc_pkg::req_type             item,
   output logic                          item_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic                          rsp_hit,
   output logic                          rsp_present,
   output logic [SW-1:0]                 rsp_slot,
   output logic [sckc_pkg::LEN_W-1:0]    rsp_length,
   output logic [CW-1:0]                 rsp_evictions_now,
   output logic [sckc_pkg::KEY_W-1:0]    rsp_evicted_x,
   output logic [sckc_pkg::KEY_W-1:0]    rsp_evicted_z,
   output logic [sckc_pkg::STAT_W-1:0]   rsp_hits_total,
   output logic [sckc_pkg::STAT_W-1:0]   rsp_misses_total,
   output logic [sckc_pkg::STAT_W-1:0]   rsp_evictions_total,
   output logic [CW-1:0]                 rsp_entries_held
);

   typedef enum logic [11:0] {
      ST_IDLE    = 12'b000000000001,
      ST_SC_RING = 12'b000000000010,
      ST_SC_KEY  = 12'b000000000100,
      ST_SC_CMP  = 12'b000000001000,
      ST_MISS    = 12'b000000010000,
      ST_EV_TEST = 12'b000000100000,
      ST_EV_RING = 12'b000001000000,
      ST_EV_REF  = 12'b000010000000,
      ST_EV_CHK  = 12'b000100000000,
      ST_EV_KEY  = 12'b001000000000,
      ST_IN_RD   = 12'b010000000000,
      ST_IN_WR   = 12'b100000000000
   } state_type;

   localparam int KW = sckc_pkg::KEY_W;
   localparam int LW = sckc_pkg::LEN_W;
   localparam int TW = sckc_pkg::STAT_W;

   function automatic logic [SW-1:0] wrap_add(logic [31:0] a, logic [31:0] b);
      logic [31:0] s;
      s = a + b;
      if (s >= 32'(CAPACITY)) begin
         s = s - 32'(CAPACITY);
      end
      return SW'(s);
   endfunction

   function automatic logic [TW-1:0] sat_inc(logic [TW-1:0] c);
      return (c == sckc_pkg::STAT_MAX) ? c : c + TW'(1);
   endfunction

   state_type state_ff, state_in;
   logic [sckc_pkg::CFG_W-1:0] max_ff, max_in;
   logic [SW-1:0] head_ff, head_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [CW-1:0] fresh_ff, fresh_in;
   logic [SW-1:0] eqh_ff, eqh_in;
   logic [CW-1:0] eqc_ff, eqc_in;
   logic [TW-1:0] hits_ff, hits_in, miss_ff, miss_in, evt_ff, evt_in;
   sckc_pkg::req_type cur_ff, cur_in;
   logic [SW-1:0] pos_ff, pos_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [CW-1:0] evn_ff, evn_in;
   logic [KW-1:0] evx_ff, evx_in, evz_ff, evz_in;
   logic [CW-1:0] lim;
   logic [31:0]   lim32;

   // result register
   logic          rv_ff, rv_in;
   logic          r_hit_ff, r_hit_in, r_pres_ff, r_pres_in;
   logic [SW-1:0] r_slot_ff, r_slot_in;
   logic [LW-1:0] r_len_ff, r_len_in;
   logic [CW-1:0] r_evn_ff, r_evn_in, r_occ_ff, r_occ_in;
   logic [KW-1:0] r_evx_ff, r_evx_in, r_evz_ff, r_evz_in;
   logic [TW-1:0] r_hits_ff, r_hits_in, r_miss_ff, r_miss_in, r_evt_ff, r_evt_in;

   // memory ports
   logic          key_we, ref_we, ring_we, evq_we;
   logic [SW-1:0] key_waddr, key_raddr, ref_waddr, ref_raddr;
   logic [SW-1:0] ring_waddr, ring_raddr, evq_waddr, evq_raddr;
   logic          ref_wdata, ref_rdata;
   logic [SW-1:0] ring_wdata, ring_rdata, evq_wdata, evq_rdata;
   logic [KW-1:0] kx_rdata, kz_rdata;
   logic [LW-1:0] len_rdata;
   logic [SW-1:0] new_slot;
   logic          take_fresh;

   sckc_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_key_x (
      .clock(clock), .we(key_we), .waddr(key_waddr), .wdata(cur_ff.chunk_x),
      .raddr(key_raddr), .rdata(kx_rdata));
   sckc_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_key_z (
      .clock(clock), .we(key_we), .waddr(key_waddr), .wdata(cur_ff.chunk_z),
      .raddr(key_raddr), .rdata(kz_rdata));
   sckc_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_len (
      .clock(clock), .we(key_we), .waddr(key_waddr), .wdata(cur_ff.fill_length),
      .raddr(key_raddr), .rdata(len_rdata));
   sckc_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_ref (
      .clock(clock), .we(ref_we), .waddr(ref_waddr), .wdata(ref_wdata),
      .raddr(ref_raddr), .rdata(ref_rdata));
   sckc_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_ring (
      .clock(clock), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
      .raddr(ring_raddr), .rdata(ring_rdata));
   sckc_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_evq (
      .clock(clock), .we(evq_we), .waddr(evq_waddr), .wdata(evq_wdata),
      .raddr(evq_raddr), .rdata(evq_rdata));

   assign rsp_empty           = !rv_ff;
   assign rsp_hit             = r_hit_ff;
   assign rsp_present         = r_pres_ff;
   assign rsp_slot            = r_slot_ff;
   assign rsp_length          = r_len_ff;
   assign rsp_evictions_now   = r_evn_ff;
   assign rsp_evicted_x       = r_evx_ff;
   assign rsp_evicted_z       = r_evz_ff;
   assign rsp_hits_total      = r_hits_ff;
   assign rsp_misses_total    = r_miss_ff;
   assign rsp_evictions_total = r_evt_ff;
   assign rsp_entries_held    = r_occ_ff;

   // effective entry limit: zero acts as one, clamp to capacity
   always_comb begin
      lim32 = 32'(max_ff);
      if (lim32 == 32'd0) begin
         lim32 = 32'd1;
      end else if (lim32 > 32'(CAPACITY)) begin
         lim32 = 32'(CAPACITY);
      end
      lim = CW'(lim32);
   end

   assign take_fresh = (32'(fresh_ff) < 32'(CAPACITY));
   assign new_slot   = take_fresh ? SW'(fresh_ff) : evq_rdata;

   always_comb begin
      state_in = state_ff;
      max_in   = csr_we ? csr_wdata : max_ff;
      head_in  = head_ff;
      occ_in   = occ_ff;
      fresh_in = fresh_ff;
      eqh_in   = eqh_ff;
      eqc_in   = eqc_ff;
      hits_in  = hits_ff;
      miss_in  = miss_ff;
      evt_in   = evt_ff;
      cur_in   = cur_ff;
      pos_in   = pos_ff;
      idx_in   = idx_ff;
      slot_in  = slot_ff;
      evn_in   = evn_ff;
      evx_in   = evx_ff;
      evz_in   = evz_ff;

      rv_in     = rv_ff && !rsp_pop;
      r_hit_in  = r_hit_ff;
      r_pres_in = r_pres_ff;
      r_slot_in = r_slot_ff;
      r_len_in  = r_len_ff;
      r_evn_in  = r_evn_ff;
      r_evx_in  = r_evx_ff;
      r_evz_in  = r_evz_ff;
      r_hits_in = r_hits_ff;
      r_miss_in = r_miss_ff;
      r_evt_in  = r_evt_ff;
      r_occ_in  = r_occ_ff;

      item_pop   = 1'b0;
      key_we     = 1'b0;
      key_waddr  = slot_ff;
      key_raddr  = slot_ff;
      ref_we     = 1'b0;
      ref_waddr  = slot_ff;
      ref_wdata  = 1'b0;
      ref_raddr  = ring_rdata;
      ring_we    = 1'b0;
      ring_waddr = wrap_add(32'(head_ff), 32'(occ_ff));
      ring_wdata = slot_ff;
      ring_raddr = head_ff;
      evq_we     = 1'b0;
      evq_waddr  = wrap_add(32'(eqh_ff), 32'(eqc_ff));
      evq_wdata  = slot_ff;
      evq_raddr  = eqh_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid && !rv_ff) begin
               item_pop = 1'b1;
               cur_in   = item;
               pos_in   = head_ff;
               idx_in   = '0;
               evn_in   = '0;
               evx_in   = '0;
               evz_in   = '0;
               state_in = (occ_ff == '0) ? ST_MISS : ST_SC_RING;
            end
         end
         ST_SC_RING: begin
            ring_raddr = pos_ff;
            state_in   = ST_SC_KEY;
         end
         ST_SC_KEY: begin
            key_raddr = ring_rdata;
            slot_in   = ring_rdata;
            state_in  = ST_SC_CMP;
         end
         ST_SC_CMP: begin
            if (kx_rdata == cur_ff.chunk_x && kz_rdata == cur_ff.chunk_z) begin
               ref_we    = 1'b1;
               ref_wdata = 1'b1;
               hits_in   = sat_inc(hits_ff);
               rv_in     = 1'b1;
               r_hit_in  = 1'b1;
               r_pres_in = 1'b1;
               r_slot_in = slot_ff;
               r_len_in  = len_rdata;
               r_evn_in  = '0;
               r_evx_in  = '0;
               r_evz_in  = '0;
               r_hits_in = sat_inc(hits_ff);
               r_miss_in = miss_ff;
               r_evt_in  = evt_ff;
               r_occ_in  = occ_ff;
               state_in  = ST_IDLE;
            end else begin
               idx_in   = idx_ff + CW'(1);
               pos_in   = wrap_add(32'(pos_ff), 32'd1);
               state_in = (idx_ff + CW'(1) == occ_ff) ? ST_MISS : ST_SC_RING;
            end
         end
         ST_MISS: begin
            miss_in = sat_inc(miss_ff);
            if (cur_ff.fill_ok) begin
               state_in = ST_EV_TEST;
            end else begin
               rv_in     = 1'b1;
               r_hit_in  = 1'b0;
               r_pres_in = 1'b0;
               r_slot_in = '0;
               r_len_in  = '0;
               r_evn_in  = '0;
               r_evx_in  = '0;
               r_evz_in  = '0;
               r_hits_in = hits_ff;
               r_miss_in = sat_inc(miss_ff);
               r_evt_in  = evt_ff;
               r_occ_in  = occ_ff;
               state_in  = ST_IDLE;
            end
         end
         ST_EV_TEST: begin
            state_in = (occ_ff >= lim) ? ST_EV_RING : ST_IN_RD;
         end
         ST_EV_RING: begin
            ring_raddr = head_ff;
            state_in   = ST_EV_REF;
         end
         ST_EV_REF: begin
            ref_raddr = ring_rdata;
            slot_in   = ring_rdata;
            state_in  = ST_EV_CHK;
         end
         ST_EV_CHK: begin
            head_in = wrap_add(32'(head_ff), 32'd1);
            if (ref_rdata) begin
               // second chance: clear bit, move to newest
               ref_we    = 1'b1;
               ref_wdata = 1'b0;
               ring_we   = 1'b1;
               state_in  = ST_EV_RING;
            end else begin
               occ_in    = occ_ff - CW'(1);
               evq_we    = 1'b1;
               eqc_in    = eqc_ff + CW'(1);
               key_raddr = slot_ff;
               state_in  = ST_EV_KEY;
            end
         end
         ST_EV_KEY: begin
            evx_in   = kx_rdata;
            evz_in   = kz_rdata;
            evn_in   = evn_ff + CW'(1);
            evt_in   = sat_inc(evt_ff);
            state_in = ST_EV_TEST;
         end
         ST_IN_RD: begin
            evq_raddr = eqh_ff;
            state_in  = ST_IN_WR;
         end
         ST_IN_WR: begin
            if (take_fresh) begin
               fresh_in = fresh_ff + CW'(1);
            end else begin
               eqh_in = wrap_add(32'(eqh_ff), 32'd1);
               eqc_in = eqc_ff - CW'(1);
            end
            key_we     = 1'b1;
            key_waddr  = new_slot;
            ref_we     = 1'b1;
            ref_waddr  = new_slot;
            ref_wdata  = 1'b1;
            ring_we    = 1'b1;
            ring_wdata = new_slot;
            occ_in     = occ_ff + CW'(1);
            rv_in      = 1'b1;
            r_hit_in   = 1'b0;
            r_pres_in  = 1'b1;
            r_slot_in  = new_slot;
            r_len_in   = cur_ff.fill_length;
            r_evn_in   = evn_ff;
            r_evx_in   = evx_ff;
            r_evz_in   = evz_ff;
            r_hits_in  = hits_ff;
            r_miss_in  = miss_ff;
            r_evt_in   = evt_ff;
            r_occ_in   = occ_ff + CW'(1);
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         max_ff   <= sckc_pkg::CFG_RESET;
         head_ff  <= '0;
         occ_ff   <= '0;
         fresh_ff <= '0;
         eqh_ff   <= '0;
         eqc_ff   <= '0;
         hits_ff  <= '0;
         miss_ff  <= '0;
         evt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         max_ff   <= max_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
         fresh_ff <= fresh_in;
         eqh_ff   <= eqh_in;
         eqc_ff   <= eqc_in;
         hits_ff  <= hits_in;
         miss_ff  <= miss_in;
         evt_ff   <= evt_in;
         rv_ff    <= rv_in;
      end
      cur_ff    <= cur_in;
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      slot_ff   <= slot_in;
      evn_ff    <= evn_in;
      evx_ff    <= evx_in;
      evz_ff    <= evz_in;
      r_hit_ff  <= r_hit_in;
      r_pres_ff <= r_pres_in;
      r_slot_ff <= r_slot_in;
      r_len_ff  <= r_len_in;
      r_evn_ff  <= r_evn_in;
      r_evx_ff  <= r_evx_in;
      r_evz_ff  <= r_evz_in;
      r_hits_ff <= r_hits_in;
      r_miss_ff <= r_miss_in;
      r_evt_ff  <= r_evt_in;
      r_occ_ff  <= r_occ_in;
   end

endmodule
